/* rtl/mrq_pkg.sv */
// Package with the shared types and constants of the message ring queue.
`timescale 1ns / 1ps

package mrq_pkg;

    // Number of slots in the queue.
    localparam int DEPTH = 16;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int ID_W  = 16;
    localparam int PAY_W = 32;
    localparam int OCC_W = 5;

    // Operation codes carried by an input transfer.
    typedef enum logic [1:0] {
        KIND_ENQUEUE = 2'd0,
        KIND_DEQUEUE = 2'd1,
        KIND_ACK     = 2'd2,
        KIND_DELETE  = 2'd3
    } t_kind;

    // Status codes carried by a result transfer.
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    // Contents of one slot.
    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [PAY_W-1:0] payload;
    } t_slot;

    // What a cell loads at the next clock edge.
    typedef enum logic [1:0] {
        CELL_HOLD  = 2'd0,
        CELL_SHIFT = 2'd1,
        CELL_WRAP  = 2'd2,
        CELL_LOAD  = 2'd3
    } t_cell_cmd;

endpackage

/* rtl/mrq_if.sv */
// Handshake interfaces for the request and result channels of the queue.
`timescale 1ns / 1ps

interface mrq_req_if import mrq_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [1:0]       kind;
    logic [PAY_W-1:0] payload;
    logic [ID_W-1:0]  target_id;

    modport source (output valid, output kind, output payload, output target_id,
                    input ready);
    modport sink   (input valid, input kind, input payload, input target_id,
                    output ready);
endinterface

interface mrq_rsp_if import mrq_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [1:0]       status;
    logic [ID_W-1:0]  msg_id;
    logic [PAY_W-1:0] msg_payload;
    logic [OCC_W-1:0] occupancy;

    modport source (output valid, output status, output msg_id, output msg_payload,
                    output occupancy, input ready);
    modport sink   (input valid, input status, input msg_id, input msg_payload,
                    input occupancy, output ready);
endinterface

/* rtl/mrq_cell.sv */
// One storage cell of the queue chain, holding a single message slot.
`timescale 1ns / 1ps

module mrq_cell import mrq_pkg::*; (
    input  logic      i_clk,
    input  t_cell_cmd i_cmd,
    input  t_slot     i_next,
    input  t_slot     i_wrap,
    input  t_slot     i_load,
    output t_slot     o_slot
);

    t_slot r_slot;
    t_slot n_slot;

    // Select the source of the next slot contents.
    always_comb begin
        case (i_cmd)
            CELL_SHIFT: n_slot = i_next;
            CELL_WRAP:  n_slot = i_wrap;
            CELL_LOAD:  n_slot = i_load;
            default:    n_slot = r_slot;
        endcase
    end

    // Slot contents carry no reset.
    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
    end

    assign o_slot = r_slot;

endmodule

/* rtl/message_ring_queue_with_delete.sv */
// Enqueue, dequeue and ack results are registered at the edge after the transfer,
// and a new request is taken every cycle while the result register is free or being emptied.
// Delete rotates the stored messages once past the comparator on the head cell, then registers
// its result when the result register is free, and no request is taken meanwhile.
// Synchronous active-low reset empties the queue and clears the id counter at once; the
// slot contents are not cleared and are only read after being written.
`timescale 1ns / 1ps

module message_ring_queue_with_delete import mrq_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mrq_req_if.sink   i_req,
    mrq_rsp_if.source o_rsp
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH
    } t_state;

    t_state           r_state,       n_state;
    logic             r_out_valid,   n_out_valid;
    logic [CNT_W-1:0] r_count,       n_count;
    logic [ID_W-1:0]  r_tail,        n_tail;
    logic [CNT_W-1:0] r_steps,       n_steps;
    logic             r_found,       n_found;
    logic [ID_W-1:0]  r_target,      n_target;
    t_status          r_status,      n_status;
    logic [ID_W-1:0]  r_msg_id,      n_msg_id;
    logic [PAY_W-1:0] r_msg_payload, n_msg_payload;
    logic [OCC_W-1:0] r_occ,         n_occ;

    t_cell_cmd        w_cmd  [DEPTH];
    t_slot            w_slot [DEPTH];
    t_slot            w_load;
    logic             w_out_free;
    logic             w_in_ready;
    logic             w_drop;

    assign w_out_free = !r_out_valid || o_rsp.ready;
    assign w_in_ready = (r_state == S_IDLE) && w_out_free;
    assign w_load     = '{id: r_tail, payload: i_req.payload};
    assign w_drop     = (w_slot[0].id == r_target) && !r_found;

    // Chain of cells: each takes its right neighbour, the head cell, or a new message.
    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        mrq_cell u_cell (
            .i_clk  (i_clk),
            .i_cmd  (w_cmd[k]),
            .i_next (w_slot[(k + 1 < DEPTH) ? k + 1 : k]),
            .i_wrap (w_slot[0]),
            .i_load (w_load),
            .o_slot (w_slot[k])
        );
    end

    // Control: operation decode, delete rotation and result register.
    always_comb begin
        n_state       = r_state;
        n_out_valid   = r_out_valid && !o_rsp.ready;
        n_count       = r_count;
        n_tail        = r_tail;
        n_steps       = r_steps;
        n_found       = r_found;
        n_target      = r_target;
        n_status      = r_status;
        n_msg_id      = r_msg_id;
        n_msg_payload = r_msg_payload;
        n_occ         = r_occ;
        for (int k = 0; k < DEPTH; k++) begin
            w_cmd[k] = CELL_HOLD;
        end

        case (r_state)
            S_IDLE: begin
                if (i_req.valid && w_in_ready) begin
                    case (t_kind'(i_req.kind))
                        KIND_ENQUEUE: begin
                            n_out_valid   = 1'b1;
                            n_msg_payload = '0;
                            if (r_count == CNT_W'(DEPTH)) begin
                                n_status = ST_FULL;
                                n_msg_id = '0;
                                n_occ    = OCC_W'(r_count);
                            end else begin
                                w_cmd[r_count[IDX_W-1:0]] = CELL_LOAD;
                                n_tail   = r_tail + 1'b1;
                                n_count  = r_count + 1'b1;
                                n_status = ST_OK;
                                n_msg_id = r_tail;
                                n_occ    = OCC_W'(r_count + 1'b1);
                            end
                        end
                        KIND_DEQUEUE, KIND_ACK: begin
                            n_out_valid = 1'b1;
                            if (r_count == '0) begin
                                n_status      = ST_EMPTY;
                                n_msg_id      = '0;
                                n_msg_payload = '0;
                                n_occ         = OCC_W'(r_count);
                            end else begin
                                for (int k = 0; k < DEPTH; k++) begin
                                    w_cmd[k] = CELL_SHIFT;
                                end
                                n_count       = r_count - 1'b1;
                                n_status      = ST_OK;
                                n_msg_id      = w_slot[0].id;
                                n_msg_payload = (t_kind'(i_req.kind) == KIND_DEQUEUE) ?
                                                w_slot[0].payload : '0;
                                n_occ         = OCC_W'(r_count - 1'b1);
                            end
                        end
                        KIND_DELETE: begin
                            if (r_count == '0) begin
                                n_out_valid   = 1'b1;
                                n_status      = ST_NOT_FOUND;
                                n_msg_id      = '0;
                                n_msg_payload = '0;
                                n_occ         = OCC_W'(r_count);
                            end else begin
                                n_state  = S_SEARCH;
                                n_steps  = r_count;
                                n_found  = 1'b0;
                                n_target = i_req.target_id;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_SEARCH: begin
                if (r_steps != '0) begin
                    // The head message either drops out or wraps round to the back.
                    n_steps = r_steps - 1'b1;
                    if (w_drop) begin
                        for (int k = 0; k < DEPTH; k++) begin
                            w_cmd[k] = CELL_SHIFT;
                        end
                        n_count = r_count - 1'b1;
                        n_tail  = r_tail - 1'b1;
                        n_found = 1'b1;
                    end else begin
                        for (int k = 0; k < DEPTH; k++) begin
                            if (CNT_W'(k) + 1'b1 < r_count) begin
                                w_cmd[k] = CELL_SHIFT;
                            end else if (CNT_W'(k) + 1'b1 == r_count) begin
                                w_cmd[k] = CELL_WRAP;
                            end
                        end
                    end
                end else if (w_out_free) begin
                    n_state       = S_IDLE;
                    n_out_valid   = 1'b1;
                    n_status      = r_found ? ST_OK : ST_NOT_FOUND;
                    n_msg_id      = r_found ? r_target : '0;
                    n_msg_payload = '0;
                    n_occ         = OCC_W'(r_count);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs; only control state is reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_count     <= '0;
            r_tail      <= '0;
            r_steps     <= '0;
            r_found     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_count     <= n_count;
            r_tail      <= n_tail;
            r_steps     <= n_steps;
            r_found     <= n_found;
        end
        r_target      <= n_target;
        r_status      <= n_status;
        r_msg_id      <= n_msg_id;
        r_msg_payload <= n_msg_payload;
        r_occ         <= n_occ;
    end

    assign i_req.ready       = w_in_ready;
    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_status;
    assign o_rsp.msg_id      = r_msg_id;
    assign o_rsp.msg_payload = r_msg_payload;
    assign o_rsp.occupancy   = r_occ;

    // The fill count never passes the number of slots.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("occupancy above queue depth");

    // No request is taken while a delete is rotating the chain.
    a_no_accept_in_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEARCH) |-> !i_req.ready)
        else $error("request taken during delete search");

    // A delete removes at most one message during its search.
    a_search_single_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEARCH) && r_found |=> r_count == $past(r_count))
        else $error("more than one message removed by a delete");

    // A non-delete request gives its result at the next edge.
    a_fast_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.valid && i_req.ready && (t_kind'(i_req.kind) != KIND_DELETE) |=> o_rsp.valid)
        else $error("missing result after enqueue or dequeue");

endmodule

/* bench/message_ring_queue_with_delete_tb.sv */
// Self-checking testbench for the message ring queue with delete by id.
`timescale 1ns / 1ps

module message_ring_queue_with_delete_tb;
    import mrq_pkg::*;

    // Accepted transfers after which the result side holds off for a long stretch.
    localparam int HOLD_AT     = 300;
    localparam int HOLD_CYCLES = 80;
    // Cycles left after the last result, enough for a delete through a full ring.
    localparam int SETTLE      = 3 * DEPTH + 8;

    // One request as queued for the driver.
    typedef struct packed {
        t_kind            kind;
        logic [PAY_W-1:0] payload;
        logic [ID_W-1:0]  target;
        bit               drain;
        bit               quiet;
    } t_op;

    // One predicted result.
    typedef struct packed {
        t_status          status;
        logic [ID_W-1:0]  msg_id;
        logic [PAY_W-1:0] msg_payload;
        logic [OCC_W-1:0] occupancy;
    } t_result;

    // Contents of the ring as the predictor sees it.
    typedef struct packed {
        logic [DEPTH-1:0][ID_W-1:0]  ids;
        logic [DEPTH-1:0][PAY_W-1:0] pays;
        logic [15:0]                 head;
        logic [15:0]                 tail;
        logic [7:0]                  count;
    } t_ring;

    logic clk;
    logic rst_n;

    mrq_req_if req_if ();
    mrq_rsp_if rsp_if ();

    message_ring_queue_with_delete dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if.sink),
        .o_rsp   (rsp_if.source)
    );

    t_op     pending_ops[$];
    t_result expected_results[$];
    t_ring   ring_gen;
    t_ring   ring_chk;
    int      n_predicted = 0;
    int      n_received  = 0;
    int      n_fail      = 0;
    int      hold_left   = 0;
    bit      quiet_phase = 1'b1;

    // Free-running clock, 20 ns period.
    always begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Applies one operation to a ring and works out the result it gives.
    task automatic apply_op(inout t_ring st, input t_op op, output t_result res);
        logic [15:0] c;
        int          pos;
        int          dst;
        int          src;
        int          i;
        int          j;
        bit          hit;
        res = '0;
        res.status = ST_OK;
        case (op.kind)
            KIND_ENQUEUE: begin
                if (st.count >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    pos = int'(st.tail) % DEPTH;
                    st.ids[pos]  = st.tail;
                    st.pays[pos] = op.payload;
                    res.msg_id   = st.tail;
                    st.tail      = st.tail + 16'd1;
                    st.count     = st.count + 8'd1;
                end
            end
            KIND_DEQUEUE, KIND_ACK: begin
                if (st.count == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    pos = int'(st.head) % DEPTH;
                    res.msg_id = st.ids[pos];
                    if (op.kind == KIND_DEQUEUE) begin
                        res.msg_payload = st.pays[pos];
                    end
                    st.head  = st.head + 16'd1;
                    st.count = st.count - 8'd1;
                end
            end
            default: begin
                // Delete: first match from the head, later slots close the gap.
                hit = 1'b0;
                for (i = 0; i < int'(st.count) && !hit; i++) begin
                    c = st.head + 16'(i);
                    pos = int'(c) % DEPTH;
                    if (st.ids[pos] == op.target) begin
                        for (j = i; j + 1 < int'(st.count); j++) begin
                            c = st.head + 16'(j);
                            dst = int'(c) % DEPTH;
                            c = st.head + 16'(j + 1);
                            src = int'(c) % DEPTH;
                            st.ids[dst]  = st.ids[src];
                            st.pays[dst] = st.pays[src];
                        end
                        st.tail    = st.tail - 16'd1;
                        st.count   = st.count - 8'd1;
                        res.msg_id = op.target;
                        hit = 1'b1;
                    end
                end
                if (!hit) begin
                    res.status = ST_NOT_FOUND;
                end
            end
        endcase
        res.occupancy = st.count[OCC_W-1:0];
    endtask

    // Queues one request and tracks its effect on the generation-side ring.
    task automatic add_op(input t_kind kind, input logic [PAY_W-1:0] payload,
                          input logic [ID_W-1:0] target, input bit drain, input bit quiet);
        t_op     op;
        t_result unused;
        op.kind    = kind;
        op.payload = payload;
        op.target  = target;
        op.drain   = drain;
        op.quiet   = quiet;
        apply_op(ring_gen, op, unused);
        pending_ops.push_back(op);
    endtask

    // Random traffic: phases that favour filling and emptying, deletes mostly of stored ids.
    task automatic add_random_traffic(input int n, input bit quiet_tail);
        int           r;
        int           bias;
        int           idx;
        bit           quiet;
        bit           drain;
        logic [15:0]  c;
        logic [ID_W-1:0] target;
        t_kind        kind;
        for (int i = 0; i < n; i++) begin
            bias   = ((i / 100) % 2 == 1) ? 60 : 25;
            quiet  = ((i / 150) % 4 == 3) || (quiet_tail && i >= n - 200);
            drain  = (i == 0) || (i == n / 2);
            target = ID_W'($urandom);
            r = $urandom_range(0, 99);
            if (r < bias) begin
                kind = KIND_ENQUEUE;
            end else begin
                r = $urandom_range(0, 9);
                if (r < 3) begin
                    kind = KIND_DEQUEUE;
                end else if (r < 5) begin
                    kind = KIND_ACK;
                end else begin
                    kind = KIND_DELETE;
                    if (ring_gen.count > 0 && $urandom_range(0, 3) != 0) begin
                        idx = $urandom_range(0, int'(ring_gen.count) - 1);
                        c = ring_gen.head + 16'(idx);
                        target = ring_gen.ids[int'(c) % DEPTH];
                    end
                end
            end
            add_op(kind, $urandom, target, drain, quiet);
        end
    endtask

    // Driver: offers the oldest pending request and predicts its result on each transfer.
    always @(posedge clk) begin : drive_proc
        t_op     cur;
        t_result res;
        bit      offer;
        int      gap_left;
        if (!rst_n) begin
            req_if.valid <= 1'b0;
            gap_left = 0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                cur = pending_ops.pop_front();
                apply_op(ring_chk, cur, res);
                expected_results.push_back(res);
                n_predicted++;
                if (!cur.quiet && $urandom_range(0, 3) == 0) begin
                    gap_left = $urandom_range(1, 11);
                end
            end else if (!req_if.valid && gap_left > 0) begin
                gap_left--;
            end
            offer = (pending_ops.size() > 0) && (gap_left == 0);
            // A drain point waits until every earlier result has been taken.
            if (offer && pending_ops[0].drain && n_received != n_predicted) begin
                offer = 1'b0;
            end
            if (offer) begin
                req_if.valid     <= 1'b1;
                req_if.kind      <= pending_ops[0].kind;
                req_if.payload   <= pending_ops[0].payload;
                req_if.target_id <= pending_ops[0].target;
                quiet_phase      <= pending_ops[0].quiet;
            end else begin
                req_if.valid <= 1'b0;
                quiet_phase  <= (pending_ops.size() == 0) ? 1'b1 : pending_ops[0].quiet;
            end
        end
    end

    // Long hold-off on the result side once, while requests keep coming.
    always @(posedge clk) begin : hold_proc
        int  n_taken;
        bit  hold_done;
        if (!rst_n) begin
            n_taken   = 0;
            hold_done = 1'b0;
            hold_left <= 0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                n_taken++;
            end
            if (!hold_done && n_taken >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left <= HOLD_CYCLES;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
            end
        end
    end

    // Monitor: compares each result transfer with the oldest prediction.
    always @(posedge clk) begin : monitor_proc
        t_result exp_res;
        int      stall_left;
        if (!rst_n) begin
            rsp_if.ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                n_received <= n_received + 1;
                if (expected_results.size() == 0) begin
                    n_fail++;
                    if (n_fail <= 10) begin
                        $display("%0t: result with nothing expected: status %0d id %h",
                                 $realtime, rsp_if.status, rsp_if.msg_id);
                    end
                end else begin
                    exp_res = expected_results.pop_front();
                    if (rsp_if.status !== exp_res.status || rsp_if.msg_id !== exp_res.msg_id
                        || rsp_if.msg_payload !== exp_res.msg_payload
                        || rsp_if.occupancy !== exp_res.occupancy) begin
                        n_fail++;
                        if (n_fail <= 10) begin
                            $write("%0t: mismatch: expected status %0d id %h payload %h ",
                                   $realtime, exp_res.status, exp_res.msg_id,
                                   exp_res.msg_payload);
                            $display("occupancy %0d, got status %0d id %h payload %h %s %0d",
                                     exp_res.occupancy, rsp_if.status, rsp_if.msg_id,
                                     rsp_if.msg_payload, "occupancy", rsp_if.occupancy);
                        end
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
            end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 11);
            end
            rsp_if.ready <= (stall_left == 0) && (hold_left == 0);
        end
    end

    // Stimulus, reset and the end of the run.
    initial begin
        req_if.valid     = 1'b0;
        req_if.kind      = KIND_ENQUEUE;
        req_if.payload   = '0;
        req_if.target_id = '0;
        rsp_if.ready     = 1'b0;
        rst_n            = 1'b0;
        ring_gen = '0;
        ring_chk = '0;

        // Empty ring: pops report empty, delete finds nothing.
        add_op(KIND_DEQUEUE, 32'hFFFF_FFFF, 16'h0000, 1'b0, 1'b0);
        add_op(KIND_ACK, 32'h0000_0000, 16'hFFFF, 1'b0, 1'b0);
        add_op(KIND_DELETE, 32'h0000_0000, 16'h0000, 1'b0, 1'b0);
        // Fill the ring with extreme and patterned payloads, then try one more.
        add_op(KIND_ENQUEUE, 32'h0000_0000, 16'h0000, 1'b0, 1'b0);
        add_op(KIND_ENQUEUE, 32'hFFFF_FFFF, 16'h0000, 1'b0, 1'b0);
        add_op(KIND_ENQUEUE, 32'h5555_5555, 16'h0000, 1'b0, 1'b0);
        add_op(KIND_ENQUEUE, 32'hAAAA_AAAA, 16'h0000, 1'b0, 1'b0);
        for (int i = 4; i < DEPTH; i++) begin
            add_op(KIND_ENQUEUE, 32'h0101_0101 * i, 16'h0000, 1'b0, 1'b0);
        end
        add_op(KIND_ENQUEUE, 32'hFFFF_FFFF, 16'h0000, 1'b1, 1'b0);
        // Delete at the head, in the middle and at the tail, then one that misses.
        add_op(KIND_DELETE, 32'h0, 16'd0, 1'b0, 1'b0);
        add_op(KIND_DELETE, 32'h0, 16'd7, 1'b0, 1'b0);
        add_op(KIND_DELETE, 32'h0, 16'd15, 1'b0, 1'b0);
        add_op(KIND_DELETE, 32'h0, 16'hFFFF, 1'b0, 1'b0);
        // The next enqueue reuses an id still stored; delete removes the older one.
        add_op(KIND_ENQUEUE, 32'h1234_5678, 16'h0000, 1'b0, 1'b0);
        add_op(KIND_DELETE, 32'h0, 16'd13, 1'b0, 1'b0);
        add_op(KIND_DEQUEUE, 32'h0, 16'h0000, 1'b0, 1'b0);
        add_op(KIND_ACK, 32'h0, 16'h0000, 1'b0, 1'b0);

        add_random_traffic(900, 1'b0);

        add_random_traffic(900, 1'b1);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        do begin
            @(posedge clk);
        end while (pending_ops.size() != 0 || n_received < n_predicted);
        repeat (SETTLE) @(posedge clk);
        if (expected_results.size() != 0) begin
            n_fail++;
            $display("%0d results still expected at the end", expected_results.size());
        end

        if (n_fail == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #50_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
